FILE: sv/min_max_contiguous_partition_top_defines.svh
// Assertion macros for the book partition search block.
`ifndef MIN_MAX_CONTIGUOUS_PARTITION_TOP_DEFINES_SVH
`define MIN_MAX_CONTIGUOUS_PARTITION_TOP_DEFINES_SVH

`ifndef SYNTH
`define MMCP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mmcp check failed: same cycle");
`define MMCP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mmcp check failed: next cycle");
`else
`define MMCP_ASSERT_IMP(lbl, ante, cons)
`define MMCP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: sv/mmcp_pkg.sv
// Shared types and constants for the book partition search block.
package mmcp_pkg;

	localparam int READER_W = 11;
	localparam int RES_W    = 26;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MID,
		ST_PASS,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic set_err;
		logic init_search;
		logic pass_start;
		logic pass_step;
		logic decide;
		logic clear;
	} dp_cmd_t;

	typedef struct packed {
		logic too_many;
		logic search_open;
		logic pass_done;
	} dp_stat_t;

endpackage

FILE: sv/mmcp_ctrl.sv
// Controller state machine: loading, binary search probes and result strobe.
module mmcp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               last_book,
	input  mmcp_pkg::dp_stat_t stat,
	output mmcp_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import mmcp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					if (last_book) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (stat.too_many) begin
					cmd.set_err = 1'b1;
					state_d     = ST_DONE;
				end else begin
					cmd.init_search = 1'b1;
					state_d         = ST_MID;
				end
			end
			ST_MID: begin
				if (stat.search_open) begin
					cmd.pass_start = 1'b1;
					state_d        = ST_PASS;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_PASS: begin
				// close the probe once the last read has been folded in
				if (stat.pass_done) begin
					cmd.decide = 1'b1;
					state_d    = ST_MID;
				end else begin
					cmd.pass_step = 1'b1;
				end
			end
			ST_DONE: begin
				done      = 1'b1;
				cmd.clear = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/mmcp_dp.sv
// Datapath: book memory, load totals, search bounds and greedy group counter.
module mmcp_dp #(
	parameter int MAX_BOOKS = 1024,
	parameter int PAGE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mmcp_pkg::dp_cmd_t             cmd,
	output mmcp_pkg::dp_stat_t            stat,
	input  logic [PAGE_BITS-1:0]          page_count,
	input  logic                          cfg_valid,
	input  logic [mmcp_pkg::READER_W-1:0] cfg_data,
	output logic [mmcp_pkg::RES_W-1:0]    min_max_pages,
	output logic                          too_many_readers
);
	import mmcp_pkg::*;

	localparam int CNT_W  = $clog2(MAX_BOOKS + 1);
	localparam int ADDR_W = (MAX_BOOKS > 1) ? $clog2(MAX_BOOKS) : 1;
	localparam int SUM_W  = PAGE_BITS + CNT_W;
	localparam int CMP_W  = (CNT_W > READER_W) ? CNT_W : READER_W;

	logic [PAGE_BITS-1:0] book_store [MAX_BOOKS];
	logic [PAGE_BITS-1:0] rdata_q;

	logic [CNT_W-1:0]     loaded_q;
	logic [PAGE_BITS-1:0] largest_q;
	logic [SUM_W-1:0]     total_q;
	logic [SUM_W-1:0]     low_q;
	logic [SUM_W-1:0]     high_q;
	logic [SUM_W-1:0]     mid_q;
	logic [SUM_W-1:0]     best_q;
	logic [SUM_W-1:0]     fill_q;
	logic [CNT_W-1:0]     groups_q;
	logic [CNT_W-1:0]     idx_q;
	logic                 rd_vld_q;
	logic                 err_q;
	logic [READER_W-1:0]  reader_q;

	logic                 store_room;
	logic                 rd_more;
	logic [SUM_W:0]       fill_sum;
	logic [SUM_W-1:0]     mid_d;
	logic                 fits;

	assign store_room = loaded_q < CNT_W'(MAX_BOOKS);
	assign rd_more    = idx_q < loaded_q;
	assign fill_sum   = {1'b0, fill_q} + (SUM_W + 1)'(rdata_q);
	assign mid_d      = low_q + ((high_q - low_q) >> 1);
	assign fits       = CMP_W'(groups_q) <= CMP_W'(reader_q);

	assign stat.too_many    = CMP_W'(reader_q) > CMP_W'(loaded_q);
	assign stat.search_open = low_q <= high_q;
	assign stat.pass_done   = !rd_more && !rd_vld_q;

	assign min_max_pages    = RES_W'(best_q);
	assign too_many_readers = err_q;

	always_ff @(posedge clk) begin
		if (cmd.load && store_room) begin
			book_store[loaded_q[ADDR_W-1:0]] <= page_count;
		end
		if (cmd.pass_step && rd_more) begin
			rdata_q <= book_store[idx_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q  <= '0;
			largest_q <= '0;
			total_q   <= '0;
			low_q     <= '0;
			high_q    <= '0;
			mid_q     <= '0;
			best_q    <= '0;
			fill_q    <= '0;
			groups_q  <= '0;
			idx_q     <= '0;
			rd_vld_q  <= 1'b0;
			err_q     <= 1'b0;
			reader_q  <= READER_W'(1);
		end else begin
			if (cfg_valid) begin
				reader_q <= cfg_data;
			end
			if (cmd.clear) begin
				loaded_q  <= '0;
				largest_q <= '0;
				total_q   <= '0;
				best_q    <= '0;
				err_q     <= 1'b0;
			end
			// drop books that arrive once the store is full
			if (cmd.load && store_room) begin
				loaded_q <= loaded_q + CNT_W'(1);
				total_q  <= total_q + SUM_W'(page_count);
				if (page_count > largest_q) begin
					largest_q <= page_count;
				end
			end
			if (cmd.set_err) begin
				err_q <= 1'b1;
			end
			if (cmd.init_search) begin
				low_q  <= SUM_W'(largest_q);
				high_q <= total_q;
			end
			if (cmd.pass_start) begin
				mid_q    <= mid_d;
				idx_q    <= '0;
				rd_vld_q <= 1'b0;
				groups_q <= CNT_W'(1);
				fill_q   <= '0;
			end
			if (cmd.pass_step) begin
				if (rd_more) begin
					idx_q    <= idx_q + CNT_W'(1);
					rd_vld_q <= 1'b1;
				end else begin
					rd_vld_q <= 1'b0;
				end
				if (rd_vld_q) begin
					// open a new group when the book would overflow the limit
					if (fill_sum <= {1'b0, mid_q}) begin
						fill_q <= fill_sum[SUM_W-1:0];
					end else begin
						groups_q <= groups_q + CNT_W'(1);
						fill_q   <= SUM_W'(rdata_q);
					end
				end
			end
			if (cmd.decide) begin
				if (fits) begin
					best_q <= mid_q;
					if (mid_q == '0) begin
						// limit zero fits: close the range
						low_q  <= SUM_W'(1);
						high_q <= '0;
					end else begin
						high_q <= mid_q - SUM_W'(1);
					end
				end else begin
					low_q <= mid_q + SUM_W'(1);
				end
			end
		end
	end

endmodule

FILE: sv/min_max_contiguous_partition_top.sv
// Loading accepts one book per cycle; busy stays low while books stream in.
// After the last book comes a check (with too many readers the strobe follows it at once),
// then each probe over N stored books runs a setup, N memory reads,
// a fold of the last read and a decide. Probes number about log2(total - largest + 2);
// a closing check follows the final probe, then the one-cycle result strobe, and busy
// drops the cycle after it. Reset clears the set and sets readers to 1; results never stall.
module min_max_contiguous_partition_top #(
	parameter int MAX_BOOKS = 1024,
	parameter int PAGE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [PAGE_BITS-1:0]          page_count,
	input  logic                          last_book,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mmcp_pkg::READER_W-1:0] cfg_data,
	output logic                          done,
	output logic [mmcp_pkg::RES_W-1:0]    min_max_pages,
	output logic                          too_many_readers
);
	import mmcp_pkg::*;

	`include "min_max_contiguous_partition_top_defines.svh"

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	mmcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_book (last_book),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	mmcp_dp #(
		.MAX_BOOKS (MAX_BOOKS),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.page_count       (page_count),
		.cfg_valid        (cfg_valid),
		.cfg_data         (cfg_data),
		.min_max_pages    (min_max_pages),
		.too_many_readers (too_many_readers)
	);

	`MMCP_ASSERT_NXT(a_last_starts_search, start && !busy && last_book, busy)
	`MMCP_ASSERT_NXT(a_done_returns_idle, done, !busy)
	`MMCP_ASSERT_IMP(a_done_while_busy, done, busy)
	`MMCP_ASSERT_IMP(a_error_zero_result, done && too_many_readers, min_max_pages == '0)

endmodule
